// ===== rtl/xoshiro256plus_generator_assert.svh =====
// Assertion macros for the xoshiro256+ generator.
// Used by the top level; assumes clk and rst_n exist in the including scope.
`ifndef XOSHIRO256PLUS_GENERATOR_ASSERT_SVH
`define XOSHIRO256PLUS_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Check cons in the same cycle as ante.
`define X256P_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x256p check failed");
// Check cons in the cycle after ante.
`define X256P_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("x256p check failed");
`else
`define X256P_ASSERT_SAME(label, ante, cons)
`define X256P_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/x256p_pkg.sv =====
// Shared types, constants, microcode ROM and xoshiro256 step for the generator.
// No dependencies.
package x256p_pkg;

    localparam int SKIP_FIELD_W = 16;

    typedef logic [63:0]      word_t;
    typedef logic [3:0][63:0] state_t;
    typedef logic [3:0]       pc_t;

    localparam word_t GOLDEN = 64'h9e3779b97f4a7c15;
    localparam word_t MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam word_t MIX_C2 = 64'h94d049bb133111eb;

    localparam state_t MAIN_RESET_STATE = {
        64'h238275bc38fcbe91, 64'ha706dd2f4d197e6f, 64'he220a8397b1dcdaf, 64'h0
    };

    localparam int SHIFT_T = 17;
    localparam int ROT_K   = 45;

    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_RESEED = 2'd1;
    localparam logic [1:0] CMD_SKIP   = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_OUT_MAIN = 4'd1;
    localparam logic [3:0] OP_SHX30    = 4'd2;
    localparam logic [3:0] OP_SHX27    = 4'd3;
    localparam logic [3:0] OP_MUL_LL   = 4'd4;
    localparam logic [3:0] OP_MUL_LH   = 4'd5;
    localparam logic [3:0] OP_MUL_HL   = 4'd6;
    localparam logic [3:0] OP_FIN      = 4'd7;
    localparam logic [3:0] OP_COMMIT   = 4'd8;
    localparam logic [3:0] OP_ADV      = 4'd9;
    localparam logic [3:0] OP_OUT_SCR  = 4'd10;

    localparam logic [1:0] CND_NONE      = 2'd0;
    localparam logic [1:0] CND_WORD_MORE = 2'd1;
    localparam logic [1:0] CND_IS_SKIP   = 2'd2;
    localparam logic [1:0] CND_CNT_MORE  = 2'd3;

    localparam logic KSEL_C1 = 1'b0;
    localparam logic KSEL_C2 = 1'b1;

    localparam pc_t ENTRY_DRAW = 4'd0;
    localparam pc_t ENTRY_SEED = 4'd1;
    localparam pc_t PC_MIX     = 4'd1;
    localparam pc_t PC_COMMIT  = 4'd11;
    localparam pc_t PC_ADV     = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic       ksel;
        logic [1:0] cond;
        pc_t        target;
        logic       last;
    } uword_t;

    typedef struct packed {
        logic word_more;
        logic is_skip;
        logic cnt_more;
    } dp_status_t;

    function automatic uword_t ucode_rom(input pc_t addr);
        uword_t w;
        w = '{op: OP_NOP, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b1};
        unique case (addr)
            4'd0:  w = '{op: OP_OUT_MAIN, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b1};
            4'd1:  w = '{op: OP_SHX30, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b0};
            4'd2:  w = '{op: OP_MUL_LL, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b0};
            4'd3:  w = '{op: OP_MUL_LH, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b0};
            4'd4:  w = '{op: OP_MUL_HL, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b0};
            4'd5:  w = '{op: OP_SHX27, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b0};
            4'd6:  w = '{op: OP_MUL_LL, ksel: KSEL_C2, cond: CND_NONE, target: '0, last: 1'b0};
            4'd7:  w = '{op: OP_MUL_LH, ksel: KSEL_C2, cond: CND_NONE, target: '0, last: 1'b0};
            4'd8:  w = '{op: OP_MUL_HL, ksel: KSEL_C2, cond: CND_NONE, target: '0, last: 1'b0};
            4'd9:  w = '{op: OP_FIN, ksel: KSEL_C1, cond: CND_WORD_MORE, target: PC_MIX,
                         last: 1'b0};
            4'd10: w = '{op: OP_NOP, ksel: KSEL_C1, cond: CND_IS_SKIP, target: PC_ADV,
                         last: 1'b0};
            4'd11: w = '{op: OP_COMMIT, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b1};
            4'd12: w = '{op: OP_ADV, ksel: KSEL_C1, cond: CND_CNT_MORE, target: PC_ADV,
                         last: 1'b0};
            4'd13: w = '{op: OP_OUT_SCR, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b1};
            default: w = '{op: OP_NOP, ksel: KSEL_C1, cond: CND_NONE, target: '0, last: 1'b1};
        endcase
        return w;
    endfunction

    function automatic state_t xoshiro_advance(input state_t s);
        state_t r;
        word_t  t;
        r = s;
        t = r[1] << SHIFT_T;
        r[2] = r[2] ^ r[0];
        r[3] = r[3] ^ r[1];
        r[1] = r[1] ^ r[2];
        r[0] = r[0] ^ r[3];
        r[2] = r[2] ^ t;
        r[3] = (r[3] << ROT_K) | (r[3] >> (64 - ROT_K));
        return r;
    endfunction

endpackage

// ===== rtl/xoshiro256plus_generator.sv =====
// Top level of the xoshiro256+ generator with splitmix64 seeding.
// Depends on x256p_pkg, x256p_sequencer, x256p_datapath and the assert macros.
//
// Usage: one input channel (in_valid/in_ready with command, seed, skip_count)
// and one output channel (out_valid/out_ready with value).
// A transaction is taken only while the sequencer is idle; one command runs at
// a time under a microcode program that steps once per cycle unless stalled.
// Draw: one output step loads the output register; a new command can follow
// once that step has completed.
// Reseed: 29 steps through the splitmix64 chain (three mixes of nine steps,
// each 64-bit multiply done as three 32x32 partial products), no result.
// Skip: 28 seeding steps, skip_count + 1 advance steps, one output step, and
// value is then taken from the advanced scratch state.
// Command 3 is accepted and dropped without starting the sequencer.
// The output register holds a result until taken; new commands are accepted
// meanwhile, and the sequencer halts only at its next output step while the
// receiver stalls.
// Reset loads the fixed main state and idles the sequencer; no clearing pass.
`include "xoshiro256plus_generator_assert.svh"
module xoshiro256plus_generator
    import x256p_pkg::*;
#(
    parameter int SKIP_COUNT_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [63:0]             seed,
    input  logic [SKIP_FIELD_W-1:0] skip_count,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [63:0]             value
);

    localparam int CNT_W = (SKIP_COUNT_BITS < SKIP_FIELD_W) ? SKIP_COUNT_BITS : SKIP_FIELD_W;

    logic       busy;
    uword_t     ctrl;
    dp_status_t status;
    word_t      result;
    logic       accept, start, is_out, stall, emit;
    pc_t        entry;
    logic       out_valid_reg, out_valid_next;
    word_t      value_reg;

    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;
    assign start    = accept && (command != CMD_RSVD);
    assign entry    = (command == CMD_DRAW) ? ENTRY_DRAW : ENTRY_SEED;
    assign is_out   = (ctrl.op == OP_OUT_MAIN) || (ctrl.op == OP_OUT_SCR);
    assign stall    = is_out && out_valid_reg && !out_ready;
    assign emit     = busy && is_out && !stall;

    x256p_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .entry  (entry),
        .stall  (stall),
        .status (status),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    x256p_datapath #(
        .CNT_W (CNT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .seed       (seed),
        .skip_count (skip_count[CNT_W-1:0]),
        .is_skip    (command == CMD_SKIP),
        .enable     (busy && !stall),
        .ctrl       (ctrl),
        .status     (status),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            value_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    `X256P_ASSERT_NEXT(a_start_busy, start, busy)
    `X256P_ASSERT_NEXT(a_rsvd_dropped, accept && (command == CMD_RSVD), !busy)
    `X256P_ASSERT_NEXT(a_emit_shown, emit, out_valid && (value == $past(result)))
    `X256P_ASSERT_NEXT(a_stall_holds, busy && stall, busy && (ctrl == $past(ctrl)))

endmodule

// ===== rtl/x256p_sequencer.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on x256p_pkg.
module x256p_sequencer
    import x256p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  pc_t        entry,
    input  logic       stall,
    input  dp_status_t status,
    output logic       busy,
    output uword_t     ctrl
);

    logic busy_reg, busy_next;
    pc_t  pc_reg, pc_next;
    logic jump;

    assign ctrl = ucode_rom(pc_reg);
    assign busy = busy_reg;

    always_comb
    begin
        unique case (ctrl.cond)
            CND_NONE:      jump = 1'b0;
            CND_WORD_MORE: jump = status.word_more;
            CND_IS_SKIP:   jump = status.is_skip;
            CND_CNT_MORE:  jump = status.cnt_more;
            default:       jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = entry;
        end
        else if (busy_reg && !stall)
        begin
            if (ctrl.last)
                busy_next = 1'b0;
            else if (jump)
                pc_next = ctrl.target;
            else
                pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

// ===== rtl/x256p_datapath.sv =====
// Datapath: main and scratch state, splitmix64 mixer on one 32x32 multiplier,
// skip counter. Driven by microcode control words. Depends on x256p_pkg.
module x256p_datapath
    import x256p_pkg::*;
#(
    parameter int CNT_W = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  word_t            seed,
    input  logic [CNT_W-1:0] skip_count,
    input  logic             is_skip,
    input  logic             enable,
    input  uword_t           ctrl,
    output dp_status_t       status,
    output word_t            result
);

    state_t           s_reg, s_next;
    state_t           w_reg, w_next;
    word_t            x_reg, x_next;
    word_t            acc_reg, acc_next;
    logic [1:0]       widx_reg, widx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             skip_reg, skip_next;

    word_t            kconst;
    logic [31:0]      mul_a, mul_b;
    word_t            prod;
    word_t            fin_m, fin_mg;
    word_t            seed_g;

    assign kconst = (ctrl.ksel == KSEL_C2) ? MIX_C2 : MIX_C1;
    assign mul_a  = (ctrl.op == OP_MUL_HL) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b  = (ctrl.op == OP_MUL_LH) ? kconst[63:32] : kconst[31:0];
    assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
    assign fin_m  = acc_reg ^ (acc_reg >> 31);
    assign fin_mg = fin_m + GOLDEN;
    assign seed_g = seed + GOLDEN;

    assign status.word_more = (widx_reg != 2'd3);
    assign status.is_skip   = skip_reg;
    assign status.cnt_more  = (cnt_reg != '0);

    assign result = (ctrl.op == OP_OUT_MAIN) ? (s_reg[0] + s_reg[3]) : (w_reg[0] + w_reg[3]);

    always_comb
    begin
        s_next    = s_reg;
        w_next    = w_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        widx_next = widx_reg;
        cnt_next  = cnt_reg;
        skip_next = skip_reg;
        if (start)
        begin
            w_next[0] = seed_g;
            x_next    = seed_g;
            widx_next = 2'd1;
            cnt_next  = skip_count;
            skip_next = is_skip;
        end
        else if (enable)
        begin
            case (ctrl.op) inside
                OP_OUT_MAIN: s_next = xoshiro_advance(s_reg);
                OP_SHX30:    x_next = x_reg ^ (x_reg >> 30);
                OP_SHX27:    x_next = acc_reg ^ (acc_reg >> 27);
                OP_MUL_LL:   acc_next = prod;
                OP_MUL_LH, OP_MUL_HL:
                    acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                OP_FIN:
                begin
                    w_next[widx_reg] = (widx_reg == 2'd3) ? fin_m : fin_mg;
                    x_next           = fin_mg;
                    widx_next        = widx_reg + 2'd1;
                end
                OP_COMMIT:   s_next = w_reg;
                OP_ADV:
                begin
                    if (cnt_reg != '0)
                    begin
                        w_next   = xoshiro_advance(w_reg);
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_reg <= MAIN_RESET_STATE;
        else
            s_reg <= s_next;
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        widx_reg <= widx_next;
        cnt_reg  <= cnt_next;
        skip_reg <= skip_next;
    end

endmodule
